>>> src/positional_list_engine_unit_defines.svh
// ----------------------------------------------------------------------------
// positional_list_engine_unit_defines.svh
// Assertion macros for the positional list engine.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define PLE_CHECK(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("positional list engine check failed");

// next-cycle implication
`define PLE_CHECK_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("positional list engine sequence check failed");

`endif

>>> src/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int PLE_CAPACITY = 32;
    localparam int PLE_DW       = 32;
    // position/count width wide enough for the largest supported capacity (64)
    localparam int PLE_PW       = 7;

    // operation codes
    localparam logic [2:0] F_INS  = 3'd0;
    localparam logic [2:0] F_DEL  = 3'd1;
    localparam logic [2:0] F_FWD  = 3'd2;
    localparam logic [2:0] F_BWD  = 3'd3;
    localparam logic [2:0] F_SRCH = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef logic [2:0] t_cmd;

    // cell commands
    localparam t_cmd C_NOP  = 3'd0;
    localparam t_cmd C_INS  = 3'd1;
    localparam t_cmd C_DEL  = 3'd2;
    localparam t_cmd C_ROTL = 3'd3;
    localparam t_cmd C_ROTR = 3'd4;
    localparam t_cmd C_SRCH = 3'd5;

    typedef struct packed {
        t_cmd                     cmd;
        logic [PLE_PW-1:0]        pos_idx;
        logic [PLE_PW-1:0]        count;
        logic signed [PLE_DW-1:0] value;
    } t_cell_ctrl;

endpackage

>>> src/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds a value, shifts or rotates with its neighbors and
// compares against the search key.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
    parameter int Idx = 0
) (
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  logic signed [PLE_DW-1:0] i_left,
    input  logic signed [PLE_DW-1:0] i_right,
    input  logic signed [PLE_DW-1:0] i_wrap,
    output logic signed [PLE_DW-1:0] o_data,
    output logic                     o_match
);

    localparam logic [PLE_PW-1:0] CellIdx  = PLE_PW'(Idx);
    localparam logic [PLE_PW-1:0] CellNext = PLE_PW'(Idx + 1);

    logic signed [PLE_DW-1:0] r_data;
    logic signed [PLE_DW-1:0] n_data;
    logic                     r_match;
    logic                     n_match;

    always_comb begin
        n_data  = r_data;
        n_match = r_match;
        case (i_ctrl.cmd)
            C_INS: begin
                if (CellIdx == i_ctrl.pos_idx) begin
                    n_data = i_ctrl.value;
                end else if (CellIdx > i_ctrl.pos_idx && CellIdx <= i_ctrl.count) begin
                    n_data = i_left;
                end
            end
            C_DEL: begin
                if (CellIdx >= i_ctrl.pos_idx && CellNext < i_ctrl.count) begin
                    n_data = i_right;
                end
            end
            C_ROTL: begin
                if (CellNext < i_ctrl.count) begin
                    n_data = i_right;
                end else if (CellNext == i_ctrl.count) begin
                    n_data = i_wrap;
                end
            end
            C_ROTR: begin
                if (Idx == 0) begin
                    n_data = i_wrap;
                end else if (CellIdx < i_ctrl.count) begin
                    n_data = i_left;
                end
            end
            C_SRCH: begin
                n_match = (CellIdx < i_ctrl.count) && (r_data == i_ctrl.value);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

>>> src/positional_list_engine_unit.sv
// Insert, delete, bad-position/empty/full answers and unused codes: result next cycle.
// Search: cells register the compare, then the OR over the match bits is registered.
// Traversal: n results, one per cycle while i_ready holds; S_PRER precedes backward.
// One transaction at a time: next item is taken once its last result is registered.
// Synchronous active-low reset clears state, element count and output valid;
// cell contents are not cleared.
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list kept in a row of cells that shift and rotate in place.
// ----------------------------------------------------------------------------
`include "positional_list_engine_unit_defines.svh"

module positional_list_engine_unit import ple_pkg::*; #(
    parameter int CAPACITY = PLE_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [2:0]               i_func,
    input  logic [7:0]               i_position,
    input  logic signed [PLE_DW-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [PLE_DW-1:0] o_item_value,
    output logic [1:0]               o_status,
    output logic                     o_found,
    output logic [5:0]               o_length,
    output logic                     o_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_PRER = 2'd2;
    localparam logic [1:0] S_TRAV = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_k, n_k;
    logic                     r_bwd, n_bwd;

    logic                     r_ovalid, n_ovalid;
    logic signed [PLE_DW-1:0] r_item, n_item;
    logic [1:0]               r_status, n_status;
    logic                     r_found, n_found;
    logic [5:0]               r_len, n_len;
    logic                     r_last, n_last;

    t_cell_ctrl               w_ctrl;
    logic signed [PLE_DW-1:0] w_cells [CAPACITY];
    logic [CAPACITY-1:0]      w_match;
    logic signed [PLE_DW-1:0] w_wrap;
    logic [IW-1:0]            w_tail_idx;
    logic                     w_ld;
    logic                     w_acc;
    logic                     w_emit;
    logic                     w_trav_last;
    logic [7:0]               w_pos_m1;
    logic [7:0]               w_cnt8;
    logic [7:0]               w_cntm1_8;
    logic [7:0]               w_ins_idx;
    logic [7:0]               w_del_idx;
    logic [PLE_PW-1:0]        w_cnt7;

    // ---------------- cell row ----------------
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [PLE_DW-1:0] w_left;
            logic signed [PLE_DW-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_cells[g-1];
            end
            if (g == CAPACITY - 1) begin : g_end
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cells[g+1];
            end
            ple_cell #(
                .Idx (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_left  (w_left),
                .i_right (w_right),
                .i_wrap  (w_wrap),
                .o_data  (w_cells[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    assign w_tail_idx = IW'(r_count - CW'(1));
    assign w_wrap     = (w_ctrl.cmd == C_ROTL) ? w_cells[0] : w_cells[w_tail_idx];

    // ---------------- control ----------------
    assign w_ld        = !r_ovalid || i_ready;
    assign o_ready     = (r_state == S_IDLE) && w_ld;
    assign w_acc       = i_valid && o_ready;
    assign w_trav_last = (r_k == r_count - CW'(1));

    assign w_pos_m1  = i_position - 8'd1;
    assign w_cnt8    = 8'(r_count);
    assign w_cntm1_8 = w_cnt8 - 8'd1;
    assign w_ins_idx = (w_pos_m1 > w_cnt8) ? w_cnt8 : w_pos_m1;
    assign w_del_idx = (w_pos_m1 > w_cntm1_8) ? w_cntm1_8 : w_pos_m1;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_k      = r_k;
        n_bwd    = r_bwd;
        n_ovalid = r_ovalid;
        n_item   = r_item;
        n_status = r_status;
        n_found  = r_found;
        n_len    = r_len;
        n_last   = r_last;
        w_emit   = 1'b0;
        w_cnt7   = '0;

        w_ctrl.cmd     = C_NOP;
        w_ctrl.pos_idx = '0;
        w_ctrl.count   = PLE_PW'(r_count);
        w_ctrl.value   = i_value;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    w_emit   = 1'b1;
                    n_item   = '0;
                    n_found  = 1'b0;
                    n_last   = 1'b1;
                    n_status = ST_OK;
                    unique case (i_func) inside
                        F_INS: begin
                            if (i_position == 8'd0) begin
                                n_status = ST_BADPOS;
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctrl.cmd     = C_INS;
                                w_ctrl.pos_idx = PLE_PW'(w_ins_idx);
                                n_count        = r_count + CW'(1);
                            end
                        end
                        F_DEL: begin
                            if (i_position == 8'd0) begin
                                n_status = ST_BADPOS;
                            end else if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_ctrl.cmd     = C_DEL;
                                w_ctrl.pos_idx = PLE_PW'(w_del_idx);
                                n_count        = r_count - CW'(1);
                            end
                        end
                        F_FWD, F_BWD: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_emit  = 1'b0;
                                n_k     = '0;
                                n_bwd   = (i_func == F_BWD);
                                n_state = (i_func == F_BWD) ? S_PRER : S_TRAV;
                            end
                        end
                        F_SRCH: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_emit     = 1'b0;
                                w_ctrl.cmd = C_SRCH;
                                n_state    = S_SRCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (w_ld) begin
                    w_emit   = 1'b1;
                    n_item   = '0;
                    n_status = ST_OK;
                    n_found  = |w_match;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_PRER: begin
                // bring the tail element to the front before emitting
                w_ctrl.cmd = C_ROTR;
                n_state    = S_TRAV;
            end
            S_TRAV: begin
                if (w_ld) begin
                    w_emit   = 1'b1;
                    n_item   = w_cells[0];
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_last   = w_trav_last;
                    n_k      = r_k + CW'(1);
                    // n rotations in total leave the list as it was
                    if (!r_bwd) begin
                        w_ctrl.cmd = C_ROTL;
                    end else if (!w_trav_last) begin
                        w_ctrl.cmd = C_ROTR;
                    end
                    if (w_trav_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_emit) begin
            n_ovalid = 1'b1;
            w_cnt7   = PLE_PW'(n_count);
            n_len    = w_cnt7[6] ? 6'd63 : w_cnt7[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_k      <= '0;
            r_bwd    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_k      <= n_k;
            r_bwd    <= n_bwd;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_status <= n_status;
        r_found  <= n_found;
        r_len    <= n_len;
        r_last   <= n_last;
    end

    assign o_valid      = r_ovalid;
    assign o_item_value = r_item;
    assign o_status     = r_status;
    assign o_found      = r_found;
    assign o_length     = r_len;
    assign o_last       = r_last;

    // ---------------- checks ----------------
    `PLE_CHECK(a_count_bound, 1'b1, r_count <= CW'(CAPACITY))
    `PLE_CHECK(a_nonlast_in_trav, o_valid && !o_last, r_state == S_TRAV)
    `PLE_CHECK_NXT(a_trav_keeps_count, r_state == S_TRAV || r_state == S_PRER, $stable(r_count))
    `PLE_CHECK_NXT(a_insert_grows, w_acc && i_func == F_INS && i_position != 8'd0 && r_count != CW'(CAPACITY), r_count == $past(r_count) + CW'(1))

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional list engine. A directed table walks
// the empty, bad-position and end-of-list cases, then biased random traffic
// fills the list to capacity and drains it again under four idling patterns.
// Every result is compared against an in-bench model of the cell array.
// ----------------------------------------------------------------------------
module tb;
    import ple_pkg::*;

    localparam logic [2:0] F_SPARE_LO  = 3'd5;
    localparam logic [2:0] F_SPARE_HI  = 3'd7;
    localparam int         WDOG_LIMIT  = 4000;
    localparam int         PHASE_ITEMS = 105;

    typedef struct {
        logic signed [31:0] item;
        logic [1:0]         status;
        logic               found;
        logic [5:0]         length;
        logic               last;
    } list_result_t;

    typedef struct {
        logic [2:0]         op;
        logic [7:0]         pos;
        logic signed [31:0] val;
        bit                 typed;
        logic [1:0]         t_status;
        logic [5:0]         t_len;
    } op_row_t;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_valid    = 1'b0;
    logic [2:0]               i_func     = '0;
    logic [7:0]               i_position = '0;
    logic signed [PLE_DW-1:0] i_value    = '0;
    logic                     i_ready    = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    logic signed [PLE_DW-1:0] o_item_value;
    logic [1:0]               o_status;
    logic                     o_found;
    logic [5:0]               o_length;
    logic                     o_last;

    // model of the list
    logic signed [31:0] list_cells [PLE_CAPACITY];
    int                 list_len = 0;

    list_result_t pending_results[$];
    op_row_t      op_table[$];

    int idle_pct      = 0;
    int stall_pct     = 0;
    int error_count   = 0;
    int ops_sent      = 0;
    int results_seen  = 0;
    int full_answers  = 0;
    int search_hits   = 0;
    int wdog_count    = 0;

    positional_list_engine_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_item_value (o_item_value),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_length     (o_length),
        .o_last       (o_last)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void push_result(input logic signed [31:0] item,
                                        input logic [1:0] st, input logic fnd,
                                        input logic lst);
        list_result_t r;
        r.item   = item;
        r.status = st;
        r.found  = fnd;
        r.length = (list_len > 63) ? 6'd63 : list_len[5:0];
        r.last   = lst;
        pending_results.push_back(r);
    endfunction

    // advance the list model by one operation and queue what it answers
    function automatic void predict_list_op(input logic [2:0] op, input logic [7:0] pos,
                                            input logic signed [31:0] val);
        int n;
        int idx;
        int src;
        bit hit;
        n = list_len;
        case (op)
            F_INS: begin
                if (pos == 8'd0) begin
                    push_result('0, ST_BADPOS, 1'b0, 1'b1);
                end else if (n >= PLE_CAPACITY) begin
                    full_answers++;
                    push_result('0, ST_FULL, 1'b0, 1'b1);
                end else begin
                    idx = (int'(pos) - 1 > n) ? n : int'(pos) - 1;
                    for (int i = n; i > idx; i--) list_cells[i] = list_cells[i-1];
                    list_cells[idx] = val;
                    list_len = n + 1;
                    push_result('0, ST_OK, 1'b0, 1'b1);
                end
            end
            F_DEL: begin
                // bad position wins over empty
                if (pos == 8'd0) begin
                    push_result('0, ST_BADPOS, 1'b0, 1'b1);
                end else if (n == 0) begin
                    push_result('0, ST_EMPTY, 1'b0, 1'b1);
                end else begin
                    idx = (int'(pos) - 1 > n - 1) ? n - 1 : int'(pos) - 1;
                    for (int i = idx; i + 1 < n; i++) list_cells[i] = list_cells[i+1];
                    list_len = n - 1;
                    push_result('0, ST_OK, 1'b0, 1'b1);
                end
            end
            F_FWD, F_BWD: begin
                if (n == 0) begin
                    push_result('0, ST_EMPTY, 1'b0, 1'b1);
                end else begin
                    for (int k = 0; k < n; k++) begin
                        src = (op == F_FWD) ? k : n - 1 - k;
                        push_result(list_cells[src], ST_OK, 1'b0, k == n - 1);
                    end
                end
            end
            F_SRCH: begin
                if (n == 0) begin
                    push_result('0, ST_EMPTY, 1'b0, 1'b1);
                end else begin
                    hit = 1'b0;
                    for (int i = 0; i < n; i++) if (list_cells[i] == val) hit = 1'b1;
                    if (hit) search_hits++;
                    push_result('0, ST_OK, hit, 1'b1);
                end
            end
            default: push_result('0, ST_OK, 1'b0, 1'b1);
        endcase
    endfunction

    // entered and left at a falling edge; valid stays up for a back-to-back item
    task automatic send_op(input op_row_t row);
        list_result_t typed_res;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= row.op;
        i_position <= row.pos;
        i_value    <= row.val;
        do @(posedge i_clk); while (!o_ready);
        predict_list_op(row.op, row.pos, row.val);
        if (row.typed) begin
            // hand-written answer replaces the single predicted one
            void'(pending_results.pop_back());
            typed_res.item   = '0;
            typed_res.status = row.t_status;
            typed_res.found  = 1'b0;
            typed_res.length = row.t_len;
            typed_res.last   = 1'b1;
            pending_results.push_back(typed_res);
        end
        ops_sent++;
        @(negedge i_clk);
    endtask

    function automatic void add_row(input logic [2:0] op, input logic [7:0] pos,
                                    input logic signed [31:0] val, input bit typed,
                                    input logic [1:0] st, input logic [5:0] len);
        op_row_t r;
        r.op       = op;
        r.pos      = pos;
        r.val      = val;
        r.typed    = typed;
        r.t_status = st;
        r.t_len    = len;
        op_table.push_back(r);
    endfunction

    task automatic run_random_phase(input int n_items);
        op_row_t row;
        int      roll;
        int      ins_pct;
        int      del_pct;
        for (int k = 0; k < n_items; k++) begin
            // fill toward capacity, then mix, then drain
            if (k < n_items / 2) begin
                ins_pct = 85;
                del_pct = 5;
            end else if (k < 3 * n_items / 4) begin
                ins_pct = 35;
                del_pct = 30;
            end else begin
                ins_pct = 15;
                del_pct = 65;
            end
            roll = $urandom_range(99);
            if (roll < ins_pct) begin
                row.op = F_INS;
            end else if (roll < ins_pct + del_pct) begin
                row.op = F_DEL;
            end else begin
                roll = $urandom_range(99);
                if (roll < 35)      row.op = F_SRCH;
                else if (roll < 60) row.op = F_FWD;
                else if (roll < 85) row.op = F_BWD;
                else                row.op = 3'($urandom_range(F_SPARE_LO, F_SPARE_HI));
            end
            roll = $urandom_range(99);
            if (roll < 8)       row.pos = 8'd0;
            else if (roll < 16) row.pos = 8'hFF;
            else if (roll < 30) row.pos = 8'($urandom_range(255));
            else                row.pos = 8'($urandom_range(1, list_len + 1));
            roll = $urandom_range(99);
            if (row.op == F_SRCH && list_len > 0 && roll < 50)
                row.val = list_cells[$urandom_range(list_len - 1)];
            else if (roll < 55) row.val = 32'($urandom_range(15)) - 32'sd8;
            else if (roll < 60) row.val = 32'sh8000_0000;
            else if (roll < 65) row.val = 32'sh7FFF_FFFF;
            else                row.val = $urandom;
            row.typed = 1'b0;
            send_op(row);
        end
    endtask

    always @(posedge i_clk) begin
        list_result_t exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result item=%0d status=%0d found=%0d len=%0d last=%0d",
                         $time, o_item_value, o_status, o_found, o_length, o_last);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_item_value !== exp_r.item || o_status !== exp_r.status ||
                    o_found !== exp_r.found || o_length !== exp_r.length ||
                    o_last !== exp_r.last) begin
                    error_count++;
                    $display("%0t: mismatch exp item=%0d status=%0d found=%0d len=%0d last=%0d",
                             $time, exp_r.item, exp_r.status, exp_r.found, exp_r.length,
                             exp_r.last);
                    $display("%0t:          act item=%0d status=%0d found=%0d len=%0d last=%0d",
                             $time, o_item_value, o_status, o_found, o_length, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            wdog_count <= 0;
        end else if (wdog_count >= WDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, WDOG_LIMIT, pending_results.size());
            $display("tb: FAIL");
            $finish;
        end else begin
            wdog_count <= wdog_count + 1;
        end
    end

    initial begin
        // empty-list answers, bad positions, both ends, extremes, spare codes
        add_row(F_DEL,  8'd1,   32'sd0,          1'b1, ST_EMPTY,  6'd0);
        add_row(F_DEL,  8'd0,   32'sd0,          1'b1, ST_BADPOS, 6'd0);
        add_row(F_FWD,  8'd0,   32'sd0,          1'b1, ST_EMPTY,  6'd0);
        add_row(F_BWD,  8'd0,   32'sd0,          1'b1, ST_EMPTY,  6'd0);
        add_row(F_SRCH, 8'd0,   32'sd0,          1'b1, ST_EMPTY,  6'd0);
        add_row(F_INS,  8'd0,   32'sd5,          1'b1, ST_BADPOS, 6'd0);
        add_row(F_INS,  8'd5,   32'sh7FFF_FFFF,  1'b1, ST_OK,     6'd1);
        add_row(F_INS,  8'd1,   32'sh8000_0000,  1'b1, ST_OK,     6'd2);
        add_row(F_INS,  8'hFF,  -32'sd1,         1'b1, ST_OK,     6'd3);
        add_row(F_INS,  8'd2,   32'sd0,          1'b1, ST_OK,     6'd4);
        add_row(F_FWD,  8'd0,   32'sd0,          1'b0, ST_OK,     6'd0);
        add_row(F_BWD,  8'hFF,  32'sd0,          1'b0, ST_OK,     6'd0);
        add_row(F_SRCH, 8'd0,   32'sh8000_0000,  1'b0, ST_OK,     6'd0);
        add_row(F_SRCH, 8'd0,   32'sd12345,      1'b0, ST_OK,     6'd0);
        add_row(F_SPARE_LO, 8'd1, 32'sd9,        1'b1, ST_OK,     6'd4);
        add_row(F_SPARE_LO + 3'd1, 8'hAA, 32'sh5555_5555, 1'b1, ST_OK, 6'd4);
        add_row(F_SPARE_HI, 8'h55, 32'shAAAA_AAAA, 1'b1, ST_OK,   6'd4);
        add_row(F_DEL,  8'd0,   32'sd0,          1'b1, ST_BADPOS, 6'd4);
        add_row(F_DEL,  8'hFF,  32'sd0,          1'b1, ST_OK,     6'd3);
        add_row(F_DEL,  8'd1,   32'sd0,          1'b1, ST_OK,     6'd2);
        add_row(F_FWD,  8'd0,   32'sd0,          1'b0, ST_OK,     6'd0);
        add_row(F_DEL,  8'd2,   32'sd0,          1'b1, ST_OK,     6'd1);
        add_row(F_DEL,  8'd1,   32'sd0,          1'b1, ST_OK,     6'd0);
        add_row(F_BWD,  8'd0,   32'sd0,          1'b1, ST_EMPTY,  6'd0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (op_table[i]) send_op(op_table[i]);

        // no idling, sender idle, receiver stall, both
        run_random_phase(PHASE_ITEMS);
        idle_pct = 48;
        run_random_phase(PHASE_ITEMS);
        idle_pct  = 0;
        stall_pct = 48;
        run_random_phase(PHASE_ITEMS);
        idle_pct  = 14;
        stall_pct = 14;
        run_random_phase(PHASE_ITEMS);

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("summary: %0d operations, %0d results checked, %0d list-full answers",
                 ops_sent, results_seen, full_answers);
        $display("summary: %0d searches hit, %0d mismatches", search_hits, error_count);
        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+src
src/ple_pkg.sv
src/ple_cell.sv
src/positional_list_engine_unit.sv
sim/tb.sv
